// ----- rtl/md4_pkg.sv -----
// ----------------------------------------------------------------------------
// md4_pkg
// Shared constants and round tables for the MD4 digest engine.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 48;

    localparam logic [31:0] MD4_K1 = 32'h5A827999;
    localparam logic [31:0] MD4_K2 = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam logic [31:0] MD4_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [1:0] STAGE_F = 2'd0;
    localparam logic [1:0] STAGE_G = 2'd1;
    localparam logic [1:0] STAGE_H = 2'd2;

    function automatic logic [3:0] md4_word_order(input logic [5:0] rnd);
        logic [3:0] w;
        begin
            case (rnd[5:4])
                STAGE_F: w = rnd[3:0];
                STAGE_G: w = {rnd[1:0], rnd[3:2]};
                STAGE_H: w = {rnd[0], rnd[1], rnd[2], rnd[3]};
                default: w = 4'd0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [4:0] md4_rot(input logic [5:0] rnd);
        logic [4:0] s;
        begin
            s = 5'd3;
            case (rnd[5:4])
                STAGE_F: begin
                    case (rnd[1:0])
                        2'd0:    s = 5'd3;
                        2'd1:    s = 5'd7;
                        2'd2:    s = 5'd11;
                        default: s = 5'd19;
                    endcase
                end
                STAGE_G: begin
                    case (rnd[1:0])
                        2'd0:    s = 5'd3;
                        2'd1:    s = 5'd5;
                        2'd2:    s = 5'd9;
                        default: s = 5'd13;
                    endcase
                end
                STAGE_H: begin
                    case (rnd[1:0])
                        2'd0:    s = 5'd3;
                        2'd1:    s = 5'd9;
                        2'd2:    s = 5'd11;
                        default: s = 5'd15;
                    endcase
                end
                default: s = 5'd3;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- rtl/md4_digest_engine_unit.sv -----
// ----------------------------------------------------------------------------
// md4_digest_engine_unit
// MD4 hash of a byte stream, digest returned as 16 little-endian bytes.
// ----------------------------------------------------------------------------
// A byte transaction is taken while the engine is idle. When a transaction
// completes a 64-byte block, the input stalls while the block is compressed:
// a start state that issues the first read, 48 rounds in the single round
// unit, which reads one message word per cycle from the block memory, and one
// chaining update. A transaction with message_end adds one compression, or two
// when 56 or more bytes are buffered (on top of a full-block compression if its
// byte fills the block), and then 16 digest transactions, after which the
// engine is reloaded for the next message.
module md4_digest_engine_unit
    import md4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_byte_present,
    input  logic       s_message_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_digest_byte,
    output logic       m_digest_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bitcnt_reg, bitcnt_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] wk_reg [4];
    logic [31:0] wk_next [4];
    logic [6:0]  fill_reg, fill_next;
    logic        mark_reg, mark_next;
    logic        len_reg, len_next;
    logic        end_reg, end_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [31:0] rd_data_reg;

    logic [31:0] blk_mem [BLOCK_WORDS];
    logic        mem_we;
    logic [3:0]  mem_raddr;

    logic        in_fire;
    logic        out_fire;
    logic [3:0]  widx;
    logic [31:0] msg_word;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] rot_val;
    logic [5:0]  end_fill;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign mem_we   = in_fire && s_byte_present;

    assign m_digest_byte = chain_reg[oidx_reg[3:2]][{oidx_reg[1:0], 3'b000} +: 8];
    assign m_digest_last = (oidx_reg == 4'd15);

    assign widx      = md4_word_order(round_reg);
    assign mem_raddr = (state_reg == ST_START) ? md4_word_order(6'd0)
                                               : md4_word_order(6'(round_reg + 6'd1));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            blk_mem[bytes_reg[5:2]][{bytes_reg[1:0], 3'b000} +: 8] <= s_byte_value;
        end
        rd_data_reg <= blk_mem[mem_raddr];
    end

    // Padding and length bytes are substituted as the word leaves the memory.
    always_comb begin
        logic [5:0] j;
        for (int b = 0; b < 4; b++) begin
            j = {widx, 2'(b)};
            if ({1'b0, j} < fill_reg) begin
                msg_word[8*b +: 8] = rd_data_reg[8*b +: 8];
            end else if (mark_reg && ({1'b0, j} == fill_reg)) begin
                msg_word[8*b +: 8] = PAD_MARK;
            end else if (len_reg && (j >= 6'd56)) begin
                msg_word[8*b +: 8] = bitcnt_reg[{j[2:0], 3'b000} +: 8];
            end else begin
                msg_word[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        case (round_reg[5:4])
            STAGE_F: begin
                f_val = (wk_reg[1] & wk_reg[2]) | (~wk_reg[1] & wk_reg[3]);
                k_val = 32'h0;
            end
            STAGE_G: begin
                f_val = (wk_reg[1] & wk_reg[2]) | (wk_reg[1] & wk_reg[3])
                      | (wk_reg[2] & wk_reg[3]);
                k_val = MD4_K1;
            end
            default: begin
                f_val = wk_reg[1] ^ wk_reg[2] ^ wk_reg[3];
                k_val = MD4_K2;
            end
        endcase
        sum      = wk_reg[0] + f_val + msg_word + k_val;
        rot_wide = {sum, sum} << md4_rot(round_reg);
        rot_val  = rot_wide[63:32];
    end

    assign end_fill = s_byte_present ? 6'(bytes_reg + 6'd1) : bytes_reg;

    always_comb begin
        state_next  = state_reg;
        round_next  = round_reg;
        bytes_next  = bytes_reg;
        bitcnt_next = bitcnt_reg;
        fill_next   = fill_reg;
        mark_next   = mark_reg;
        len_next    = len_reg;
        end_next    = end_reg;
        oidx_next   = oidx_reg;
        chain_next  = chain_reg;
        wk_next     = wk_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_byte_present) begin
                        bytes_next  = 6'(bytes_reg + 6'd1);
                        bitcnt_next = bitcnt_reg + 64'd8;
                    end
                    if (s_byte_present && (bytes_reg == 6'd63)) begin
                        fill_next  = 7'd64;
                        mark_next  = 1'b0;
                        len_next   = 1'b0;
                        end_next   = s_message_end;
                        state_next = ST_START;
                    end else if (s_message_end) begin
                        fill_next  = {1'b0, end_fill};
                        mark_next  = 1'b1;
                        len_next   = (end_fill < 6'd56);
                        end_next   = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                wk_next    = chain_reg;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                wk_next[0] = wk_reg[3];
                wk_next[1] = rot_val;
                wk_next[2] = wk_reg[1];
                wk_next[3] = wk_reg[2];
                round_next = 6'(round_reg + 6'd1);
                if (round_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 4; i++) begin
                    chain_next[i] = chain_reg[i] + wk_reg[i];
                end
                if (!mark_reg && !len_reg) begin
                    if (end_reg) begin
                        fill_next  = 7'd0;
                        mark_next  = 1'b1;
                        len_next   = 1'b1;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (!len_reg) begin
                    fill_next  = 7'd0;
                    mark_next  = 1'b0;
                    len_next   = 1'b1;
                    state_next = ST_START;
                end else begin
                    oidx_next  = 4'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    oidx_next = 4'(oidx_reg + 4'd1);
                    if (oidx_reg == 4'd15) begin
                        chain_next  = MD4_IV;
                        bytes_next  = 6'd0;
                        bitcnt_next = 64'd0;
                        end_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            round_reg  <= 6'd0;
            bytes_reg  <= 6'd0;
            bitcnt_reg <= 64'd0;
            fill_reg   <= 7'd0;
            mark_reg   <= 1'b0;
            len_reg    <= 1'b0;
            end_reg    <= 1'b0;
            oidx_reg   <= 4'd0;
            chain_reg  <= MD4_IV;
        end else begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            bytes_reg  <= bytes_next;
            bitcnt_reg <= bitcnt_next;
            fill_reg   <= fill_next;
            mark_reg   <= mark_next;
            len_reg    <= len_next;
            end_reg    <= end_next;
            oidx_reg   <= oidx_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg <= wk_next;
    end

endmodule

// ----- rtl/md4_checker.sv -----
// ----------------------------------------------------------------------------
// md4_checker
// Port-level assertions for the MD4 digest engine, bound to md4_digest_engine_unit.
// ----------------------------------------------------------------------------
module md4_checker
    import md4_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_message_end,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_digest_byte,
    input logic       m_digest_last
);

    // The engine never takes input while a digest is being delivered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest is valid");

    // A transaction that ends a message is followed by a stall for compression.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_message_end) |=> !s_ready)
        else $error("input ready right after message end");

    // The last digest byte closes the output burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_digest_last) |=> (!m_valid && s_ready))
        else $error("output continued after last digest byte");

    // A stalled digest byte holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_byte)
                                   && $stable(m_digest_last)))
        else $error("stalled digest transaction changed");

endmodule

bind md4_digest_engine_unit md4_checker u_md4_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_message_end (s_message_end),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_byte (m_digest_byte),
    .m_digest_last (m_digest_last)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for md4_digest_engine_unit. Byte transactions are driven with
// random gaps, except in every fifth random message. A class tracks the MD4
// state of each message and keeps a queue of the digest bytes each final
// transaction must produce. Every digest transaction is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
    import md4_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } digest_out_t;

    class md4_digest_tracker;
        localparam logic [31:0] IV0 = 32'h67452301;
        localparam logic [31:0] IV1 = 32'hefcdab89;
        localparam logic [31:0] IV2 = 32'h98badcfe;
        localparam logic [31:0] IV3 = 32'h10325476;
        localparam logic [31:0] ROOT2 = 32'h5A827999;
        localparam logic [31:0] ROOT3 = 32'h6ED9EBA1;
        localparam logic [7:0]  END_MARK = 8'h80;

        logic [31:0] chain [4];
        logic [7:0]  block_buf [64];
        logic [5:0]  fill;
        logic [63:0] bit_total;
        digest_out_t digest_bytes_due [$];
        int          mismatches;
        int unsigned word_sel [48] = '{
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
            0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
            0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
        };
        int unsigned shift_sel [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

        function new();
            mismatches = 0;
            foreach (block_buf[i]) block_buf[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            chain[0] = IV0;
            chain[1] = IV1;
            chain[2] = IV2;
            chain[3] = IV3;
            fill = 6'd0;
            bit_total = 64'd0;
        endfunction

        function logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] r [4];
            logic [31:0] x, y, z, f, k;
            int unsigned t, stage;
            for (int i = 0; i < 16; i++) begin
                w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
            end
            r = chain;
            for (int i = 0; i < 48; i++) begin
                t = (4 - (i % 4)) % 4;
                x = r[(t + 1) % 4];
                y = r[(t + 2) % 4];
                z = r[(t + 3) % 4];
                stage = i / 16;
                if (stage == 0) begin
                    f = (x & y) | (~x & z);
                    k = 32'd0;
                end else if (stage == 1) begin
                    f = (x & y) | (x & z) | (y & z);
                    k = ROOT2;
                end else begin
                    f = x ^ y ^ z;
                    k = ROOT3;
                end
                r[t] = rotl(r[t] + f + w[word_sel[i]] + k, shift_sel[stage * 4 + i % 4]);
            end
            for (int i = 0; i < 4; i++) chain[i] = chain[i] + r[i];
        endfunction

        function void absorb_item(input logic [7:0] b, input logic p, input logic e);
            int n;
            digest_out_t d;
            if (p) begin
                block_buf[fill] = b;
                fill = fill + 6'd1;
                bit_total = bit_total + 64'd8;
                if (fill == 6'd0) compress();
            end
            if (!e) return;
            n = fill;
            block_buf[n] = END_MARK;
            n++;
            if (n > 56) begin
                while (n < 64) begin
                    block_buf[n] = 8'h00;
                    n++;
                end
                compress();
                n = 0;
            end
            while (n < 56) begin
                block_buf[n] = 8'h00;
                n++;
            end
            for (int i = 0; i < 8; i++) block_buf[56 + i] = bit_total[8*i +: 8];
            compress();
            for (int i = 0; i < 16; i++) begin
                d.value = chain[i / 4][8 * (i % 4) +: 8];
                d.last = (i == 15);
                digest_bytes_due.push_back(d);
            end
            restart();
        endfunction

        function void check_digest_byte(input logic [7:0] value, input logic last);
            digest_out_t d;
            if (digest_bytes_due.size() == 0) begin
                $display("%0t: unexpected digest byte, expected none actual %02h last %0b",
                         $time, value, last);
                mismatches++;
                return;
            end
            d = digest_bytes_due.pop_front();
            if (value !== d.value) begin
                $display("%0t: digest_byte expected %02h actual %02h", $time, d.value, value);
                mismatches++;
            end
            if (last !== d.last) begin
                $display("%0t: digest_last expected %0b actual %0b", $time, d.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_byte_value;
    logic       s_byte_present;
    logic       s_message_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_digest_byte;
    logic       m_digest_last;

    md4_digest_tracker sb;
    int items_sent;
    bit hold_burst;
    bit no_gaps;

    md4_digest_engine_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_value  (s_byte_value),
        .s_byte_present(s_byte_present),
        .s_message_end (s_message_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_byte (m_digest_byte),
        .m_digest_last (m_digest_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= b;
        s_byte_present <= p;
        s_message_end <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.absorb_item(b, p, e);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message(input int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item($urandom_range(0, 255), 1'b0, 1'b0);
            send_item($urandom_range(0, 255), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) send_item($urandom_range(0, 255), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.digest_bytes_due.size() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_digest_byte(m_digest_byte, m_digest_last);
    end

    initial begin
        int quiet;
        quiet = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_burst) begin
                hold_burst = 1'b0;
                quiet = 400;
            end
            if (quiet > 0) begin
                m_ready <= 1'b0;
                quiet--;
            end else begin
                m_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 3) == 0) quiet = pick_gap();
            end
        end
    end

    initial begin
        #4000000;
        $display("FAIL md4_digest_engine_unit");
        $finish;
    end

    initial begin
        int msg;
        int len;
        int random_goal;
        sb = new();
        items_sent = 0;
        hold_burst = 1'b0;
        no_gaps = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_byte_value = 8'h00;
        s_byte_present = 1'b0;
        s_message_end = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);

        random_goal = 165;
        msg = 0;
        while ((items_sent < random_goal) || (msg < 4)) begin
            if (msg == 1) hold_burst = 1'b1;
            no_gaps = (msg % 5 == 4);
            if (msg == 0) begin
                len = $urandom_range(56, 64);
            end else if ($urandom_range(0, 99) < 60) begin
                len = $urandom_range(0, 9);
            end else begin
                len = $urandom_range(54, 66);
            end
            send_message(len);
            if (msg == 3) wait_digests_drained();
            msg++;
        end
        no_gaps = 1'b0;

        wait_digests_drained();
        repeat (200) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("PASS md4_digest_engine_unit");
        end else begin
            $display("FAIL md4_digest_engine_unit");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/md4_pkg.sv
rtl/md4_digest_engine_unit.sv
rtl/md4_checker.sv
test/tb_top.sv
